// File: hdl/mrp_pkg.sv
// Shared types, constants, the base table and the modular adder of the Miller-Rabin prime test.
`default_nettype none

package mrp_pkg;

    localparam int unsigned WIDTH      = 64;
    localparam int unsigned BASE_COUNT = 12;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned SHIFT_W    = 6;
    localparam int unsigned BASE_W     = 6;

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SHIFT_W-1:0] t_shift;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SPLIT = 9'b000000010,
        S_BASE  = 9'b000000100,
        S_POW   = 9'b000001000,
        S_POWSQ = 9'b000010000,
        S_CHK0  = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    typedef enum logic {
        D_ACC = 1'b0,
        D_X   = 1'b1
    } t_dst;

    function automatic logic [BASE_W-1:0] mrp_base(input t_idx idx);
        logic [BASE_W-1:0] b;
        case (idx)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            4'd11:   b = 6'd37;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

    // Both operands must already be below the modulus.
    function automatic t_word mrp_madd(input t_word x, input t_word y, input t_word m);
        logic [WIDTH:0] sum;
        logic [WIDTH:0] diff;
        t_word          r;
        sum  = {1'b0, x} + {1'b0, y};
        diff = sum - {1'b0, m};
        if (sum >= {1'b0, m}) begin
            r = diff[WIDTH-1:0];
        end else begin
            r = sum[WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mrp_if.sv
// Valid/ready channel interfaces for the candidate input and the verdict output.
`default_nettype none

interface mrp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] n;

    modport source (output valid, output n, input ready);
    modport sink   (input valid, input n, output ready);
endinterface

interface mrp_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// File: hdl/miller_rabin_prime_test_64_core.sv
// Deterministic Miller-Rabin primality test core for unsigned 64-bit candidates.
`default_nettype none

// The core accepts one candidate n per transaction on i_in and returns one verdict on o_out,
// working on one candidate at a time. Even numbers, 0, 1 and 2 are settled without trying any base.
// For odd n, n-1 is split into q * 2^k one bit per cycle, then each base (2, 3, 5, ... up to
// the first NUM_BASES, at most twelve) below n-1 is raised to q and squared up to k times.
// Every modular product runs on a single double-and-add multiplier that consumes one
// multiplier bit per cycle. Composites usually end after the first base. A finished verdict
// is held in an output register until taken, and the next candidate is accepted as soon as
// the verdict has been handed to that register.
module miller_rabin_prime_test_64_core #(
    parameter int unsigned NUM_BASES = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mrp_in_if.sink      i_in,
    mrp_out_if.source   o_out
);
    import mrp_pkg::*;

    localparam int unsigned LIMIT_I = (NUM_BASES > BASE_COUNT) ? BASE_COUNT : NUM_BASES;
    localparam t_idx        LIMIT   = IDX_W'(LIMIT_I);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_dst   r_mdst, n_mdst;
    t_word  r_n, n_n;
    t_word  r_q, n_q;
    t_word  r_e, n_e;
    t_word  r_acc, n_acc;
    t_word  r_x, n_x;
    t_word  r_ma, n_ma;
    t_word  r_mb, n_mb;
    t_word  r_macc, n_macc;
    t_shift r_k, n_k;
    t_shift r_j, n_j;
    t_idx   r_idx, n_idx;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    logic   r_out_bit, n_out_bit;

    t_word  nm1;
    t_word  base;

    assign nm1  = r_n - t_word'(1);
    assign base = t_word'(mrp_base(r_idx));

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.is_prime = r_out_bit;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_mdst      = r_mdst;
        n_n         = r_n;
        n_q         = r_q;
        n_e         = r_e;
        n_acc       = r_acc;
        n_x         = r_x;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_macc      = r_macc;
        n_k         = r_k;
        n_j         = r_j;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_n = i_in.n;
                    if (i_in.n == t_word'(2)) begin
                        n_res   = 1'b1;
                        n_state = S_FIN;
                    end else if (!i_in.n[0] || i_in.n == t_word'(1)) begin
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_q     = i_in.n - t_word'(1);
                        n_k     = '0;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (r_q[0]) begin
                    n_idx   = '0;
                    n_state = S_BASE;
                end else begin
                    n_q = r_q >> 1;
                    n_k = r_k + t_shift'(1);
                end
            end
            S_BASE: begin
                if (r_idx == LIMIT || base >= nm1) begin
                    n_res   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_acc   = t_word'(1);
                    n_x     = base;
                    n_e     = r_q;
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_e == '0) begin
                    n_state = S_CHK0;
                end else if (r_e[0]) begin
                    n_ma    = r_acc;
                    n_mb    = r_x;
                    n_macc  = '0;
                    n_mdst  = D_ACC;
                    n_ret   = S_POWSQ;
                    n_state = S_MUL;
                end else begin
                    n_state = S_POWSQ;
                end
            end
            S_POWSQ: begin
                n_e     = r_e >> 1;
                n_ma    = r_x;
                n_mb    = r_x;
                n_macc  = '0;
                n_mdst  = D_X;
                n_ret   = S_POW;
                n_state = S_MUL;
            end
            S_CHK0: begin
                if (r_acc == t_word'(1)) begin
                    n_idx   = r_idx + t_idx'(1);
                    n_state = S_BASE;
                end else begin
                    n_j     = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_j == r_k) begin
                    n_res   = 1'b0;
                    n_state = S_FIN;
                end else if (r_acc == nm1) begin
                    n_idx   = r_idx + t_idx'(1);
                    n_state = S_BASE;
                end else begin
                    n_j     = r_j + t_shift'(1);
                    n_ma    = r_acc;
                    n_mb    = r_acc;
                    n_macc  = '0;
                    n_mdst  = D_ACC;
                    n_ret   = S_CHK;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_mb == '0) begin
                    if (r_mdst == D_X) begin
                        n_x = r_macc;
                    end else begin
                        n_acc = r_macc;
                    end
                    n_state = r_ret;
                end else begin
                    if (r_mb[0]) begin
                        n_macc = mrp_madd(r_macc, r_ma, r_n);
                    end
                    n_ma = mrp_madd(r_ma, r_ma, r_n);
                    n_mb = r_mb >> 1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret     <= n_ret;
        r_mdst    <= n_mdst;
        r_n       <= n_n;
        r_q       <= n_q;
        r_e       <= n_e;
        r_acc     <= n_acc;
        r_x       <= n_x;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_macc    <= n_macc;
        r_k       <= n_k;
        r_j       <= n_j;
        r_idx     <= n_idx;
        r_res     <= n_res;
        r_out_bit <= n_out_bit;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the 64-bit Miller-Rabin prime test core.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrp_pkg::*;

    localparam int unsigned BASES_USED = 12;
    localparam t_word WITNESSES [BASE_COUNT] = '{
        64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
        64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
    };

    typedef struct {
        t_word n;
        logic  is_prime;
    } t_verdict_exp;

    logic i_clk;
    logic i_rst_n;

    mrp_in_if  cand_if ();
    mrp_out_if verdict_if ();

    miller_rabin_prime_test_64_core #(
        .NUM_BASES (BASES_USED)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cand_if),
        .o_out   (verdict_if)
    );

    t_verdict_exp verdict_q[$];
    int unsigned  fail_count;
    bit           idling_on;
    int unsigned  verdict_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_word modsum(input t_word x, input t_word y, input t_word m);
        t_word a;
        t_word b;
        a = x % m;
        b = y % m;
        if (a >= m - b) begin
            return a - (m - b);
        end
        return a + b;
    endfunction

    function automatic t_word modprod(input t_word x, input t_word y, input t_word m);
        t_word acc;
        t_word addend;
        t_word mult;
        acc    = '0;
        addend = x;
        mult   = y;
        while (mult != 0) begin
            if (mult[0]) begin
                acc = modsum(acc, addend, m);
            end
            mult   = mult >> 1;
            addend = modsum(addend, addend, m);
        end
        return acc;
    endfunction

    function automatic t_word modexp(input t_word x, input t_word e, input t_word m);
        t_word acc;
        t_word sq;
        t_word ex;
        acc = 64'd1;
        sq  = x;
        ex  = e;
        while (ex != 0) begin
            if (ex[0]) begin
                acc = modprod(acc, sq, m);
            end
            ex = ex >> 1;
            sq = modprod(sq, sq, m);
        end
        return acc;
    endfunction

    function automatic logic predict_primality(input t_word n);
        t_word       q;
        t_word       v;
        int unsigned k;
        int unsigned limit;
        logic        hit;
        if (n == 64'd2) begin
            return 1'b1;
        end
        if (!n[0] || n == 64'd1) begin
            return 1'b0;
        end
        q = n - 64'd1;
        k = 0;
        while (!q[0]) begin
            k++;
            q = q >> 1;
        end
        limit = (BASES_USED > BASE_COUNT) ? BASE_COUNT : BASES_USED;
        for (int unsigned i = 0; i < limit; i++) begin
            if (WITNESSES[i] >= n - 64'd1) begin
                break;
            end
            v = modexp(WITNESSES[i], q, n);
            if (v == 64'd1) begin
                continue;
            end
            hit = 1'b0;
            for (int unsigned j = 0; j < k; j++) begin
                if (v == n - 64'd1) begin
                    hit = 1'b1;
                    break;
                end
                v = modprod(v, v, n);
            end
            if (!hit) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_candidate(input t_word n);
        t_verdict_exp e;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            cand_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cand_if.valid <= 1'b1;
        cand_if.n     <= n;
        do @(posedge i_clk); while (!cand_if.ready);
        e.n        = n;
        e.is_prime = predict_primality(n);
        verdict_q.push_back(e);
    endtask

    // Small values, both ends of the range and the cases where few or no bases are tried.
    task automatic test_edge_values();
        t_word vals [18] = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25, 64'd37, 64'd38,
            64'd39, 64'd41, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'd561, 64'd7919
        };
        foreach (vals[i]) begin
            send_candidate(vals[i]);
        end
    endtask

    // Large primes and strong pseudoprimes that survive the first bases.
    task automatic test_hard_candidates();
        t_word vals [6] = '{
            64'd2047, 64'd3215031751, 64'd3825123056546413051,
            64'd2305843009213693951, 64'd9223372036854775783, 64'd18446744073709551557
        };
        foreach (vals[i]) begin
            send_candidate(vals[i]);
        end
    endtask

    // The core is drained first so that quick candidates fill it during the long hold.
    task automatic test_output_backpressure();
        cand_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        verdict_hold_cycles = 400;
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) begin
                send_candidate({$urandom, $urandom} & ~64'd1);
            end else begin
                send_candidate(64'($urandom_range(0, 5)));
            end
        end
    endtask

    task automatic test_random_candidates(input int count);
        t_word n;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    n = {$urandom, $urandom} & ~64'd1;
                2, 3, 4: n = 64'($urandom_range(3, 65535)) | 64'd1;
                5, 6, 7: n = 64'($urandom) | 64'd1;
                default: n = {$urandom, $urandom} | 64'd1;
            endcase
            send_candidate(n);
        end
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_candidate(64'($urandom_range(0, 4095)));
        end
    endtask

    initial begin
        fail_count          = 0;
        idling_on           = 1'b1;
        verdict_hold_cycles = 0;
        i_rst_n       <= 1'b0;
        cand_if.valid <= 1'b0;
        cand_if.n     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_hard_candidates();
        test_output_backpressure();
        test_random_candidates(65);
        test_back_to_back();

        cand_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        verdict_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (verdict_hold_cycles != 0) begin
                verdict_if.ready <= 1'b0;
                repeat (verdict_hold_cycles) @(posedge i_clk);
                verdict_hold_cycles = 0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                verdict_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                verdict_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict_exp e;
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual is_prime=%0b",
                         $time, verdict_if.is_prime);
                fail_count++;
            end else begin
                e = verdict_q.pop_front();
                if (verdict_if.is_prime !== e.is_prime) begin
                    $display("%0t: n=%0d is_prime expected %0b, actual %0b",
                             $time, e.n, e.is_prime, verdict_if.is_prime);
                    fail_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire
